>>> rtl/hbp_pkg.sv
// ----------------------------------------------------------------------------
// hbp_pkg
// Types, constants and word formats shared by the huffman bit packer files.
// ----------------------------------------------------------------------------
package hbp_pkg;

  localparam int SYMBOL_COUNT = 256;
  localparam int MAX_CODE_LEN = 32;
  localparam int IDX_W        = $clog2(SYMBOL_COUNT);
  localparam int LEN_CAP      = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;
  localparam int CODE_W       = 32;
  localparam int LEN_W        = 6;
  localparam int ENTRY_W      = CODE_W + LEN_W;
  localparam int PEND_W       = 7;
  localparam int ACC_W        = PEND_W + CODE_W;
  localparam int TOTAL_W      = 40;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_ENCODE = 2'd1;
  localparam logic [1:0] CMD_END    = 2'd2;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_FINAL = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [7:0]        symbol;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_len;
    logic              entry_present;
  } hbp_in_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         out_byte;
    logic [TOTAL_W-1:0] total_bits;
    logic               last;
  } hbp_out_t;

  // looked-up item handed from the table stage to the packer
  typedef struct packed {
    logic              vld;
    logic              is_end;
    logic              hit;
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
  } hbp_item_t;

endpackage

>>> rtl/hbp_ram.sv
// ----------------------------------------------------------------------------
// hbp_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module hbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/hbp_packer.sv
// ----------------------------------------------------------------------------
// hbp_packer
// Bit accumulator, saturating bit count and output register; emits one
// result word per cycle while out_stall does not hold the output register.
// ----------------------------------------------------------------------------
module hbp_packer (
  input  logic               clk,
  input  logic               rst_n,
  input  hbp_pkg::hbp_item_t item,
  output logic               take,
  output logic               out_valid,
  input  logic               out_stall,
  output hbp_pkg::hbp_out_t  out_word
);
  import hbp_pkg::*;

  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [LEN_W-1:0]   cnt_r, cnt_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic               out_vld_r, out_vld_nxt;
  hbp_out_t           out_word_r, res;

  logic               out_free;
  logic               emit;
  logic [LEN_W-1:0]   sh;
  logic [TOTAL_W-1:0] ext_len;
  logic [ACC_W-1:0]   pad;

  assign out_free = !out_vld_r || !out_stall;
  assign ext_len  = TOTAL_W'(item.len);
  assign pad      = acc_r << (LEN_W'(8) - cnt_r);

  always_comb begin
    take        = 1'b0;
    emit        = 1'b0;
    acc_nxt     = acc_r;
    cnt_nxt     = cnt_r;
    total_nxt   = total_r;
    out_vld_nxt = out_vld_r && out_stall;
    res         = '0;
    sh          = '0;
    if (out_free) begin
      out_vld_nxt = 1'b0;
      if (cnt_r >= LEN_W'(8)) begin
        emit = 1'b1;
      end else if (item.vld) begin
        take = 1'b1;
        if (item.is_end) begin
          out_vld_nxt    = 1'b1;
          res.kind       = (cnt_r != '0) ? KIND_FINAL : KIND_END;
          res.out_byte   = (cnt_r != '0) ? pad[7:0] : 8'd0;
          res.total_bits = total_r;
          res.last       = 1'b1;
          cnt_nxt        = '0;
          total_nxt      = '0;
        end else if (!item.hit) begin
          out_vld_nxt    = 1'b1;
          res.kind       = KIND_ERROR;
          res.total_bits = total_r;
          res.last       = 1'b1;
        end else begin
          acc_nxt   = (acc_r << item.len) | ACC_W'(item.code);
          cnt_nxt   = cnt_r + item.len;
          total_nxt = ((TOTAL_MAX - total_r) < ext_len) ? TOTAL_MAX : total_r + ext_len;
          emit      = cnt_nxt >= LEN_W'(8);
        end
      end
      if (emit) begin
        sh             = cnt_nxt - LEN_W'(8);
        out_vld_nxt    = 1'b1;
        res.kind       = KIND_DATA;
        res.out_byte   = 8'(acc_nxt >> sh);
        res.total_bits = total_nxt;
        res.last       = cnt_nxt < LEN_W'(16);
        cnt_nxt        = sh;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      total_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      cnt_r     <= cnt_nxt;
      total_r   <= total_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (out_free) begin
      out_word_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_word  = out_word_r;

endmodule

>>> rtl/huffman_bit_packer_unit.sv
// ----------------------------------------------------------------------------
// huffman_bit_packer_unit
// Table-driven huffman encoder: code table in RAM, present marks in flops,
// codes packed msb first into bytes.
// ----------------------------------------------------------------------------
//   channel   dir  handshake           word
//   in        in   in_valid/in_stall    hbp_in_t  (cmd, symbol, code, length)
//   out       out  out_valid/out_stall  hbp_out_t (kind, byte, total, last)
//
// an item passes through the table read stage, then the packer; a code
// leaving eight or more pending bits holds the packer until under eight
// remain, one result word per cycle via the output register when unstalled.
// a load item is written to the table at acceptance and yields nothing.
// reset clears the present marks, pending count, bit count and valids at once.
// out_stall freezes the output register; the stall backs up to in_stall.
// ----------------------------------------------------------------------------
module huffman_bit_packer_unit (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  hbp_pkg::hbp_in_t in_word,
  output logic             out_valid,
  input  logic             out_stall,
  output hbp_pkg::hbp_out_t out_word
);
  import hbp_pkg::*;

  logic                    in_acc;
  logic                    in_range;
  logic [IDX_W-1:0]        idx;
  logic [LEN_W-1:0]        lim_len;
  logic [CODE_W-1:0]       code_mask;
  logic                    tab_we, tab_re;
  logic [ENTRY_W-1:0]      tab_wdata, tab_rdata;
  logic [SYMBOL_COUNT-1:0] present_r;
  logic                    s1_vld_r, s1_vld_nxt;
  logic                    s1_end_r, s1_hit_r;
  logic                    take;
  hbp_item_t               item;

  assign in_acc    = in_valid && !in_stall;
  assign in_range  = {1'b0, in_word.symbol} < 9'(SYMBOL_COUNT);
  assign idx       = in_word.symbol[IDX_W-1:0];
  assign lim_len   = (in_word.code_len > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : in_word.code_len;
  assign code_mask = ~({CODE_W{1'b1}} << lim_len);
  assign tab_wdata = {lim_len, in_word.code_bits & code_mask};
  assign tab_we    = in_acc && (in_word.cmd == CMD_LOAD) && in_range;
  assign tab_re    = in_acc && (in_word.cmd == CMD_ENCODE);

  hbp_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(SYMBOL_COUNT)
  ) u_code_ram (
    .clk  (clk),
    .we   (tab_we),
    .waddr(idx),
    .wdata(tab_wdata),
    .re   (tab_re),
    .raddr(idx),
    .rdata(tab_rdata)
  );

  always_comb begin
    s1_vld_nxt = s1_vld_r && !take;
    if (in_acc) begin
      s1_vld_nxt = (in_word.cmd == CMD_ENCODE) || (in_word.cmd == CMD_END);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= '0;
      s1_vld_r  <= 1'b0;
    end else begin
      if (tab_we) begin
        present_r[idx] <= in_word.entry_present;
      end
      s1_vld_r <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_end_r <= in_word.cmd == CMD_END;
      s1_hit_r <= in_range && present_r[idx];
    end
  end

  assign in_stall = s1_vld_r && !take;

  assign item.vld    = s1_vld_r;
  assign item.is_end = s1_end_r;
  assign item.hit    = s1_hit_r;
  assign item.len    = tab_rdata[ENTRY_W-1:CODE_W];
  assign item.code   = tab_rdata[CODE_W-1:0];

  hbp_packer u_packer (
    .clk      (clk),
    .rst_n    (rst_n),
    .item     (item),
    .take     (take),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

endmodule

>>> rtl/hbp_checker.sv
// ----------------------------------------------------------------------------
// hbp_checker
// Port-level checks on the huffman bit packer, bound to the top level.
// ----------------------------------------------------------------------------
module hbp_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input hbp_pkg::hbp_in_t  in_word,
  input logic              out_valid,
  input logic              out_stall,
  input hbp_pkg::hbp_out_t out_word
);
  import hbp_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result word changed under stall");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // end and error results close their item
  a_nondata_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.kind != KIND_DATA) |-> out_word.last)
    else $error("end or error result without last");

  a_empty_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_word.kind == KIND_END) || (out_word.kind == KIND_ERROR))
    |-> out_word.out_byte == 8'd0)
    else $error("end or error result carries a byte");

  // a stalled input word holds until taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_word))
    else $error("input word changed under stall");

endmodule

bind huffman_bit_packer_unit hbp_checker u_hbp_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .in_word  (in_word),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_word (out_word)
);
